FILE: rtl/melody_note_decoder_top_macros.svh
// Assertion macros for the melody note decoder.
`ifndef MELODY_NOTE_DECODER_TOP_MACROS_SVH
`define MELODY_NOTE_DECODER_TOP_MACROS_SVH

// checked only out of reset
`define MND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define MND_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/mnd_pkg.sv
// Package: types, tables and constants of the melody note decoder.
`timescale 1ns / 1ps
`default_nettype none
package mnd_pkg;

  localparam int unsigned DIV_W    = 24;
  localparam int unsigned DIV_STEP = 4;
  localparam int unsigned DIV_NST  = DIV_W / DIV_STEP;

  localparam logic [13:0] FREQ_MAX = 14'h3FFF;

  localparam logic [8:0] BASE_FREQ [12] = '{
    9'd262, 9'd277, 9'd294, 9'd311, 9'd330, 9'd349,
    9'd369, 9'd392, 9'd415, 9'd440, 9'd466, 9'd494
  };

  localparam logic [3:0] NOTE_POS [7] = '{
    4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11
  };

  typedef enum logic [2:0] {
    CFG_KEY_SHIFT     = 3'd0,
    CFG_OCTAVE_SHIFT  = 3'd1,
    CFG_WHOLE_NOTE_MS = 3'd2,
    CFG_SOUND_NUM     = 3'd3,
    CFG_SOUND_DEN     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EFF_NORMAL,
    EFF_LEGATO,
    EFF_STACCATO
  } effect_e;

  typedef enum logic [1:0] {
    OCT_MID,
    OCT_LOW,
    OCT_HIGH
  } oct_e;

  typedef struct packed {
    logic        bad;
    logic        rest;
    logic [3:0]  pos;
    oct_e        octave;
    logic        dotted;
    effect_e     effect;
    logic [15:0] len;
  } dec_t;

  typedef struct packed {
    logic        bad;
    logic        rest;
    logic [13:0] freq;
    logic [15:0] len;
    effect_e     effect;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [23:0] prod;
  } scl_t;

  typedef struct packed {
    side_t       side;
    logic [7:0]  rem;
    logic [23:0] work;
  } div_t;

endpackage
`default_nettype wire

FILE: rtl/mnd_if.sv
// Request and result channel interfaces of the melody note decoder.
`timescale 1ns / 1ps
`default_nettype none
interface mnd_note_if;
  logic       valid;
  logic       ready;
  logic [7:0] tone_code;
  logic [7:0] length_code;

  modport source (output valid, tone_code, length_code, input ready);
  modport sink (input valid, tone_code, length_code, output ready);
endinterface

interface mnd_result_if;
  logic        valid;
  logic        ready;
  logic [13:0] tone_freq;
  logic [15:0] sound_ms;
  logic [15:0] silent_ms;
  logic        bad_code;

  modport source (output valid, tone_freq, sound_ms, silent_ms, bad_code, input ready);
  modport sink (input valid, tone_freq, sound_ms, silent_ms, bad_code, output ready);
endinterface
`default_nettype wire

FILE: rtl/mnd_decode.sv
// Stage 1: decimal digit split, range checks and base note length.
`timescale 1ns / 1ps
`default_nettype none
module mnd_decode
  import mnd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] whole_note_ms_i,
  input  wire logic        valid_i,
  input  wire logic [7:0]  tone_code_i,
  input  wire logic [7:0]  length_code_i,
  output      logic        ready_o,
  output      logic        valid_o,
  output      dec_t        data_o,
  input  wire logic        ready_i
);

  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [15:0] m;
    m = 16'(x) * 16'd205;
    return m[15:11];
  endfunction

  logic       v_q;
  logic       en;
  dec_t       d_d, d_q;
  logic [4:0] t_q1, l_q1;
  logic [4:0] t_q2, l_q2;
  logic [3:0] note, range_dig, value, effect_dig;
  logic [1:0] sharp;
  logic [2:0] pos_idx;
  logic [3:0] pos;

  always_comb begin
    t_q1       = div10(tone_code_i);
    l_q1       = div10(length_code_i);
    t_q2       = div10({3'b0, t_q1});
    l_q2       = div10({3'b0, l_q1});
    note       = 4'(tone_code_i - 8'({3'b0, t_q1} * 8'd10));
    value      = 4'(length_code_i - 8'({3'b0, l_q1} * 8'd10));
    range_dig  = 4'(t_q1 - 5'(t_q2 * 5'd10));
    effect_dig = 4'(l_q1 - 5'(l_q2 * 5'd10));
    sharp      = t_q2[1:0];

    pos_idx = (note == 4'd0 || note > 4'd7) ? 3'd0 : 3'(note - 4'd1);
    pos     = NOTE_POS[pos_idx] + {2'b0, sharp};

    d_d        = '0;
    d_d.rest   = (note == 4'd0);
    d_d.pos    = pos;
    d_d.dotted = (l_q2 == 5'd1);
    d_d.len    = whole_note_ms_i >> value;
    d_d.bad    = (note > 4'd7) || (note != 4'd0 && pos > 4'd11) || (value > 4'd6);

    case (range_dig)
      4'd1:    d_d.octave = OCT_LOW;
      4'd3:    d_d.octave = OCT_HIGH;
      default: d_d.octave = OCT_MID;
    endcase

    case (effect_dig)
      4'd0:    d_d.effect = EFF_NORMAL;
      4'd1:    d_d.effect = EFF_LEGATO;
      default: d_d.effect = EFF_STACCATO;
    endcase
  end

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign data_o  = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      d_q <= d_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mnd_scale.sv
// Stage 2: transposed frequency, dotted length and sounding-fraction product.
`timescale 1ns / 1ps
`default_nettype none
module mnd_scale
  import mnd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [3:0]        key_shift_i,
  input  wire logic signed [2:0] octave_shift_i,
  input  wire logic [7:0]        sound_num_i,
  input  wire logic              valid_i,
  input  wire dec_t              data_i,
  output      logic              ready_o,
  output      logic              valid_o,
  output      scl_t              data_o,
  input  wire logic              ready_i
);

  logic        v_q;
  logic        en;
  scl_t        s_d, s_q;
  logic [4:0]  j, jm;
  logic [1:0]  jq;
  logic [2:0]  oct_bits, oct_mag;
  logic [15:0] f;
  logic [16:0] len_sum;
  logic [15:0] len_d;

  always_comb begin
    j = 5'(data_i.pos) + 5'(key_shift_i);
    if (j >= 5'd24) begin
      jm = j - 5'd24;
      jq = 2'd2;
    end else if (j >= 5'd12) begin
      jm = j - 5'd12;
      jq = 2'd1;
    end else begin
      jm = j;
      jq = 2'd0;
    end

    oct_bits = octave_shift_i;
    oct_mag  = 3'(~oct_bits + 3'd1);
    f = 16'(BASE_FREQ[jm[3:0]]) << jq;
    if (oct_bits[2]) begin
      f = f >> oct_mag;
    end else begin
      f = f << oct_bits[1:0];
    end
    case (data_i.octave)
      OCT_LOW:  f = f >> 1;
      OCT_HIGH: f = f << 1;
      default:  f = f;
    endcase

    len_sum = {1'b0, data_i.len};
    if (data_i.dotted) begin
      len_sum = {1'b0, data_i.len} + {2'b0, data_i.len[15:1]};
    end
    len_d = len_sum[16] ? 16'hFFFF : len_sum[15:0];

    s_d             = '0;
    s_d.side.bad    = data_i.bad;
    s_d.side.rest   = data_i.rest;
    s_d.side.effect = data_i.effect;
    s_d.side.len    = len_d;
    if (data_i.rest) begin
      s_d.side.freq = '0;
    end else if (f > 16'(FREQ_MAX)) begin
      s_d.side.freq = FREQ_MAX;
    end else begin
      s_d.side.freq = f[13:0];
    end
    s_d.prod = 24'(len_d) * 24'(sound_num_i);
  end

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign data_o  = s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      s_q <= s_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mnd_div.sv
// Pipelined restoring divider, four quotient bits per stage, note fields ride along.
`timescale 1ns / 1ps
`default_nettype none
module mnd_div
  import mnd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       den_i,
  input  wire logic             valid_i,
  input  wire side_t            side_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  output      logic             ready_o,
  output      logic             valid_o,
  output      side_t            side_o,
  output      logic [DIV_W-1:0] quot_o,
  input  wire logic             ready_i
);

  function automatic div_t div_step(input div_t x, input logic [7:0] den);
    div_t       r;
    logic [8:0] r9;
    r = x;
    for (int b = 0; b < DIV_STEP; b++) begin
      r9     = {r.rem, r.work[DIV_W-1]};
      r.work = r.work << 1;
      if (r9 >= {1'b0, den}) begin
        r.rem     = 8'(r9 - {1'b0, den});
        r.work[0] = 1'b1;
      end else begin
        r.rem = r9[7:0];
      end
    end
    return r;
  endfunction

  logic [DIV_NST-1:0] v_q;
  logic [DIV_NST-1:0] en;
  logic [DIV_NST-1:0] v_in;
  div_t               st_in [DIV_NST];
  div_t               st_q  [DIV_NST];

  always_comb begin
    en[DIV_NST-1] = !v_q[DIV_NST-1] || ready_i;
    for (int k = DIV_NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_in[0]       = valid_i;
    st_in[0].side = side_i;
    st_in[0].rem  = '0;
    st_in[0].work = dividend_i;
    for (int k = 1; k < DIV_NST; k++) begin
      v_in[k]  = v_q[k-1];
      st_in[k] = st_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < DIV_NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_NST; k++) begin
      if (en[k] && v_in[k]) begin
        st_q[k] <= div_step(st_in[k], den_i);
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[DIV_NST-1];
  assign side_o  = st_q[DIV_NST-1].side;
  assign quot_o  = st_q[DIV_NST-1].work;

endmodule
`default_nettype wire

FILE: rtl/melody_note_decoder_top.sv
// Top level of the melody note decoder: config registers, stage chain, result register.
// Stages from request to result: decode, scale, 6 divider stages, result register.
// Throughput: one request per cycle while no stage is held by backpressure;
//   each divider stage resolves 4 quotient bits.
// Every stage holds its item under backpressure and takes a new one once it empties.
// Reset: config registers return to their defaults and all valid bits clear.
`timescale 1ns / 1ps
`default_nettype none
`include "melody_note_decoder_top_macros.svh"
module melody_note_decoder_top
  import mnd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  mnd_note_if.sink         note_in,
  mnd_result_if.source     note_out
);

  logic [3:0]        key_shift_q;
  logic signed [2:0] octave_shift_q;
  logic [15:0]       whole_note_ms_q;
  logic [7:0]        sound_num_q;
  logic [7:0]        sound_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_shift_q     <= 4'd0;
      octave_shift_q  <= 3'sd0;
      whole_note_ms_q <= 16'd1600;
      sound_num_q     <= 8'd4;
      sound_den_q     <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_SHIFT:     key_shift_q     <= cfg_data_i[3:0];
        CFG_OCTAVE_SHIFT:  octave_shift_q  <= cfg_data_i[2:0];
        CFG_WHOLE_NOTE_MS: whole_note_ms_q <= cfg_data_i;
        CFG_SOUND_NUM:     sound_num_q     <= cfg_data_i[7:0];
        CFG_SOUND_DEN:     sound_den_q     <= cfg_data_i[7:0];
        default:           ;
      endcase
    end
  end

  logic             dec_valid, dec_ready;
  dec_t             dec_data;
  logic             scl_valid, scl_ready;
  scl_t             scl_data;
  logic             div_valid, div_ready;
  side_t            div_side;
  logic [DIV_W-1:0] div_quot;

  mnd_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .whole_note_ms_i (whole_note_ms_q),
    .valid_i         (note_in.valid),
    .tone_code_i     (note_in.tone_code),
    .length_code_i   (note_in.length_code),
    .ready_o         (note_in.ready),
    .valid_o         (dec_valid),
    .data_o          (dec_data),
    .ready_i         (dec_ready)
  );

  mnd_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_shift_i    (key_shift_q),
    .octave_shift_i (octave_shift_q),
    .sound_num_i    (sound_num_q),
    .valid_i        (dec_valid),
    .data_i         (dec_data),
    .ready_o        (dec_ready),
    .valid_o        (scl_valid),
    .data_o         (scl_data),
    .ready_i        (scl_ready)
  );

  mnd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .den_i      (sound_den_q),
    .valid_i    (scl_valid),
    .side_i     (scl_data.side),
    .dividend_i (scl_data.prod),
    .ready_o    (scl_ready),
    .valid_o    (div_valid),
    .side_o     (div_side),
    .quot_o     (div_quot),
    .ready_i    (div_ready)
  );

  logic        out_v_q;
  logic        out_en;
  logic [15:0] snd;
  logic [13:0] freq_d, freq_q;
  logic [15:0] sound_d, sound_q;
  logic [15:0] silent_d, silent_q;
  logic        bad_d, bad_q;

  always_comb begin
    case (div_side.effect)
      EFF_LEGATO: snd = div_side.len;
      EFF_NORMAL: begin
        if (sound_den_q == 8'd0 || div_quot > {8'b0, div_side.len}) begin
          snd = div_side.len;
        end else begin
          snd = div_quot[15:0];
        end
      end
      default:    snd = div_side.len >> 1;
    endcase
    if (div_side.rest) begin
      snd = '0;
    end

    bad_d    = div_side.bad;
    freq_d   = div_side.freq;
    sound_d  = snd;
    silent_d = div_side.len - snd;
    if (div_side.bad) begin
      freq_d   = '0;
      sound_d  = '0;
      silent_d = '0;
    end
  end

  assign out_en    = !out_v_q || note_out.ready;
  assign div_ready = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && div_valid) begin
      freq_q   <= freq_d;
      sound_q  <= sound_d;
      silent_q <= silent_d;
      bad_q    <= bad_d;
    end
  end

  assign note_out.valid     = out_v_q;
  assign note_out.tone_freq = freq_q;
  assign note_out.sound_ms  = sound_q;
  assign note_out.silent_ms = silent_q;
  assign note_out.bad_code  = bad_q;

  `MND_ASSERT(a_bad_zero, note_out.valid && note_out.bad_code |-> note_out.tone_freq == 14'd0 && note_out.sound_ms == 16'd0 && note_out.silent_ms == 16'd0, "bad code result not zeroed")
  `MND_ASSERT(a_rest_silent, note_out.valid && !note_out.bad_code && note_out.tone_freq == 14'd0 |-> note_out.sound_ms == 16'd0, "rest sounds")
  `MND_ASSERT(a_drain, out_v_q && note_out.ready && !div_valid |=> !note_out.valid, "result repeated")
  `MND_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !note_out.valid, "result valid in reset")

endmodule
`default_nettype wire
